/* src/iwma_pkg.sv */
package iwma_pkg;

    localparam int ITEMS      = 256;
    localparam int NODES      = 64;
    localparam int CATEGORIES = 16;

    localparam int STORE_DEPTH = ITEMS * NODES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int MODE_W   = 2;
    localparam int ITEM_W   = 8;
    localparam int NODE_W   = 6;
    localparam int CAT_W    = $clog2(CATEGORIES);
    localparam int LIMIT_W  = CAT_W + 1;
    localparam int PROB_W   = 17;
    localparam int WT_W     = 32;
    localparam int THETA_W  = 16;
    localparam int ENTRY_W  = 48;
    localparam int SUM_W    = 64;
    localparam int MODEL_W  = 2;

    // shared multiplier: 33 x 18 signed, wide operand taken in two halves
    localparam int MUL_A_W  = 64;
    localparam int HALF_W   = MUL_A_W / 2;
    localparam int MUL_X_W  = HALF_W + 1;
    localparam int MUL_B_W  = PROB_W + 1;
    localparam int PART_W   = MUL_X_W + MUL_B_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int TC_W     = THETA_W + CAT_W + 1;
    localparam int CATSQ_W  = 2 * CAT_W;

    localparam int THETA_FRAC = 12;
    localparam int PROB_FRAC  = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [MODEL_W-1:0] MODEL_2PL  = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_GPCM = 2'd2;

    localparam logic KIND_MOMENT = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [ITEM_W-1:0]          item_index;
        logic [NODE_W-1:0]          node_index;
        logic [CAT_W-1:0]           category;
        logic [LIMIT_W-1:0]         category_limit;
        logic [PROB_W-1:0]          probability;
        logic [WT_W-1:0]            weight;
        logic signed [THETA_W-1:0]  theta;
        logic                       last_node;
        logic signed [ENTRY_W-1:0]  entry_value;
    } t_in_item;

    typedef struct packed {
        logic                       result_kind;
        logic [ITEM_W-1:0]          item_out;
        logic [CAT_W-1:0]           category_out;
        logic signed [SUM_W-1:0]    first_sum;
        logic signed [SUM_W-1:0]    second_sum;
        logic signed [SUM_W-1:0]    third_sum;
        logic signed [ENTRY_W-1:0]  entry_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_READ,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_WB,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_WP,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_TC,
        OP_S2
    } t_op;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic mem_rd;
        logic mul_lo;
        logic mul_hi;
        logic wb;
        logic emit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              active;
        logic              last;
        logic              in_range;
        logic              is_2pl;
        logic              is_gpcm;
        logic              out_free;
    } t_status;

endpackage

/* src/iwma_ctrl.sv */
module iwma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iwma_pkg::t_status i_status,
    output iwma_pkg::t_cmd    o_cmd
);
    import iwma_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_WP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state and next operation
    always_comb begin
        logic tail_gpcm;
        tail_gpcm = i_status.is_gpcm;
        n_state   = r_state;
        n_op      = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.mode)
                    MODE_LOAD: n_state = S_LOAD;
                    MODE_READ: n_state = S_READ;
                    MODE_SAMPLE: begin
                        if (i_status.active) begin
                            n_state = S_MUL_LO;
                            n_op    = OP_WP;
                        end else if (i_status.last) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_LOAD:   n_state = S_IDLE;
            S_READ:   n_state = S_EMIT;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_MUL_WB;
            S_MUL_WB: begin
                n_state = S_MUL_LO;
                case (r_op)
                    OP_WP: n_op = OP_M1;
                    OP_M1: n_op = OP_M2;
                    OP_M2, OP_M3: begin
                        if (i_status.is_2pl && r_op == OP_M2) begin
                            n_op = OP_M3;
                        end else if (i_status.is_gpcm && i_status.in_range) begin
                            n_op = OP_TC;
                        end else if (!i_status.last) begin
                            n_state = S_IDLE;
                        end else if (tail_gpcm) begin
                            n_op = OP_S2;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    OP_TC: begin
                        if (!i_status.last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_op = OP_S2;
                        end
                    end
                    OP_S2:   n_state = S_EMIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = r_op;
        o_in_ready    = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.capture = i_in_valid;
            S_LOAD:   o_cmd.load_wr = 1'b1;
            S_READ:   o_cmd.mem_rd  = 1'b1;
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                o_cmd.mem_rd = 1'b1;
            end
            S_MUL_HI: o_cmd.mul_hi  = 1'b1;
            S_MUL_WB: o_cmd.wb      = 1'b1;
            S_EMIT:   o_cmd.emit    = i_status.out_free;
            default:  o_cmd.capture = 1'b0;
        endcase
    end

endmodule

/* src/iwma_dp.sv */
module iwma_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iwma_pkg::t_in_item            i_in,
    input  logic                          i_cfg_wr_en,
    input  logic [iwma_pkg::MODEL_W-1:0]  i_cfg_wr_data,
    input  iwma_pkg::t_cmd                i_cmd,
    output iwma_pkg::t_status             o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output iwma_pkg::t_out_item           o_out
);
    import iwma_pkg::*;

    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

    logic [MODEL_W-1:0]         r_model;
    t_in_item                   r_in;
    logic signed [TC_W-1:0]     r_tc;
    logic [CATSQ_W-1:0]         r_catsq;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [MUL_A_W-1:0]  r_tmp;
    logic signed [SUM_W-1:0]    r_acc1;
    logic signed [SUM_W-1:0]    r_acc2;
    logic signed [SUM_W-1:0]    r_acc3;
    logic signed [SUM_W-1:0]    r_s2;
    logic signed [ENTRY_W-1:0]  r_rd;
    logic signed [ENTRY_W-1:0]  r_store [STORE_DEPTH];
    t_out_item                  r_out;
    logic                       r_out_valid;

    logic                       in_range;
    logic                       active;
    logic                       is_2pl;
    logic                       is_gpcm;
    logic                       out_free;
    logic [ADDR_W-1:0]          addr;
    logic signed [CAT_W:0]      cat_s;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_X_W-1:0]  mul_x;
    logic signed [PART_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   part_ext;
    logic signed [PROD_W-1:0]   prod_sh12;
    logic signed [PROD_W-1:0]   prod_sh16;
    logic signed [SUM_W-1:0]    m_val;
    logic signed [SUM_W-1:0]    m3_val;
    logic signed [SUM_W-1:0]    s2_val;
    logic [PROD_W-SUM_W:0]      prod_top;
    logic signed [ENTRY_W:0]    st_sum;
    logic signed [ENTRY_W-1:0]  st_new;
    logic                       wr_en;
    logic signed [ENTRY_W-1:0]  wr_data;
    t_out_item                  n_out;

    assign in_range = (32'(r_in.item_index) < ITEMS) && (32'(r_in.node_index) < NODES);
    assign active   = {1'b0, r_in.category} < r_in.category_limit;
    assign is_2pl   = (r_model == MODEL_2PL);
    assign is_gpcm  = (r_model == MODEL_GPCM);
    assign out_free = !r_out_valid || i_out_ready;
    assign addr     = ADDR_W'(r_in.item_index) * ADDR_W'(NODES) + ADDR_W'(r_in.node_index);
    assign cat_s    = {1'b0, i_in.category};

    always_comb begin
        o_status          = '0;
        o_status.mode     = r_in.mode;
        o_status.active   = active;
        o_status.last     = r_in.last_node;
        o_status.in_range = in_range;
        o_status.is_2pl   = is_2pl;
        o_status.is_gpcm  = is_gpcm;
        o_status.out_free = out_free;
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = r_tmp;
        mul_b = {{(MUL_B_W-PROB_W){1'b0}}, r_in.probability};
        case (i_cmd.op)
            OP_WP: mul_a = {{(MUL_A_W-WT_W){1'b0}}, r_in.weight};
            OP_M1, OP_M2: begin
                mul_b = {{(MUL_B_W-THETA_W){r_in.theta[THETA_W-1]}}, r_in.theta};
            end
            OP_M3: mul_a = r_tmp;
            OP_TC: mul_a = {{(MUL_A_W-TC_W){r_tc[TC_W-1]}}, r_tc};
            OP_S2: begin
                mul_a = r_acc2;
                mul_b = {{(MUL_B_W-CATSQ_W){1'b0}}, r_catsq};
            end
            default: mul_a = r_tmp;
        endcase
        if (i_cmd.mul_hi) begin
            mul_x = {mul_a[MUL_A_W-1], mul_a[MUL_A_W-1:HALF_W]};
        end else begin
            mul_x = {1'b0, mul_a[HALF_W-1:0]};
        end
    end

    assign mul_p     = PART_W'(mul_x) * PART_W'(mul_b);
    assign part_ext  = {{(PROD_W-PART_W){mul_p[PART_W-1]}}, mul_p};
    assign prod_sh12 = r_prod >>> THETA_FRAC;
    assign prod_sh16 = r_prod >>> PROB_FRAC;
    assign m_val     = prod_sh12[SUM_W-1:0];
    assign m3_val    = prod_sh16[SUM_W-1:0];
    assign prod_top  = r_prod[PROD_W-1:SUM_W-1];

    always_comb begin
        if ((&prod_top) || !(|prod_top)) begin
            s2_val = r_prod[SUM_W-1:0];
        end else begin
            s2_val = r_prod[PROD_W-1] ? SUM_MIN : SUM_MAX;
        end
        st_sum = {r_rd[ENTRY_W-1], r_rd} + r_prod[ENTRY_W:0];
        if (st_sum[ENTRY_W] != st_sum[ENTRY_W-1]) begin
            st_new = st_sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX;
        end else begin
            st_new = st_sum[ENTRY_W-1:0];
        end
        wr_en   = 1'b0;
        wr_data = r_in.entry_value;
        if (i_cmd.load_wr && in_range) begin
            wr_en = 1'b1;
        end else if (i_cmd.wb && i_cmd.op == OP_TC && in_range) begin
            wr_en   = 1'b1;
            wr_data = st_new;
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.item_out    = r_in.item_index;
        if (r_in.mode == MODE_READ) begin
            n_out.result_kind = KIND_ENTRY;
            n_out.entry_out   = in_range ? r_rd : '0;
        end else begin
            n_out.result_kind  = KIND_MOMENT;
            n_out.category_out = r_in.category;
            if (active) begin
                n_out.first_sum  = r_acc1;
                n_out.second_sum = is_gpcm ? r_s2 : r_acc2;
                n_out.third_sum  = is_2pl ? r_acc3 : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in    <= i_in;
            r_tc    <= TC_W'(i_in.theta) * TC_W'(cat_s);
            r_catsq <= CATSQ_W'(i_in.category) * CATSQ_W'(i_in.category);
        end
        if (i_cmd.mul_lo) begin
            r_prod <= part_ext;
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + (part_ext <<< HALF_W);
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                OP_WP:        r_tmp <= r_prod[SUM_W-1:0];
                OP_M1, OP_M2: r_tmp <= m_val;
                OP_S2:        r_s2  <= s2_val;
                default:      r_tmp <= r_tmp;
            endcase
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model     <= '0;
            r_acc1      <= '0;
            r_acc2      <= '0;
            r_acc3      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_model <= i_cfg_wr_data;
            end
            if (i_cmd.emit && r_in.mode != MODE_READ) begin
                r_acc1 <= '0;
                r_acc2 <= '0;
                r_acc3 <= '0;
            end else if (i_cmd.wb) begin
                case (i_cmd.op)
                    OP_M1:   r_acc1 <= sat_add(r_acc1, m_val);
                    OP_M2:   r_acc2 <= sat_add(r_acc2, m_val);
                    OP_M3:   r_acc3 <= sat_add(r_acc3, m3_val);
                    default: r_acc1 <= r_acc1;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/irt_weighted_moment_accumulator.sv */
// Weighted moment accumulator for the slope step of 2PL / GPCM models.
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one item:
// a store load, a node sample or a store read. Output channel
// (o_out_valid / i_out_ready, payload o_out) gives a moment result on
// the last node sample of a run, and one entry per store read.
// i_cfg_wr_en / i_cfg_wr_data write model_kind; write it only while idle.
// One item is worked at a time through a single shared 33x18 multiplier,
// each product in a low half, a high half and a write-back step:
//   a load passes decode and a store write, a read decode, a store read
//   and the result, a sample decode, its products and, on a last node, the result.
// A sample whose category is at or above the limit skips the products and
// goes to the result only on a last node; an unknown mode ends at decode.
// The store read-modify-write rides on the product sequence.
// The result sits in an output register; the block goes on accepting
// items while it waits, and only a new result waits for it to drain.
// Reset clears the sums, model_kind and both channels; store contents
// are undefined until loaded.
module irt_weighted_moment_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  iwma_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output iwma_pkg::t_out_item           o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [iwma_pkg::MODEL_W-1:0]  i_cfg_wr_data
);
    import iwma_pkg::*;

    t_cmd    cmd;
    t_status status;

    iwma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    iwma_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out)
    );

endmodule
